// ===== src/ole_pkg.sv =====
// Package: shared types and constants of the ordered list engine.
package ole_pkg;

  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned LenWidth = 7;
  localparam int unsigned ValWidth = 32;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_DELETE    = 3'd2,
    ACT_SEARCH    = 3'd3,
    ACT_DEDUPE    = 3'd4,
    ACT_READ_OUT  = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0]                 action;
    logic signed [ValWidth-1:0] operand_value;
  } ole_in_t;

  typedef struct packed {
    logic                       found;
    logic                       rejected;
    logic                       has_entry;
    logic signed [ValWidth-1:0] entry_value;
    logic [LenWidth-1:0]        length;
    logic                       last;
  } ole_out_t;

endpackage

// ===== src/ordered_list_engine.sv =====
// Top level: ordered list engine, a list of signed words held in one RAM.
//
//  channel | direction | handshake               | payload
//  in      | into      | in_valid_i/in_stall_o   | ole_in_t
//  out     | out of    | out_valid_o/out_stall_i | ole_out_t
//
// One transaction at a time; the input stalls from acceptance until the engine
// is idle again. Each RAM read presents the address, then uses the registered
// data. Search stops at a hit; delete, insert front and read out walk the
// whole list; dedupe runs an inner compare loop over the kept entries.
// Reset clears the length and control state only; the RAM needs no clearing.
// A stalled result holds in the output register; the engine waits on it.
module ordered_list_engine #(
  parameter int unsigned Capacity = ole_pkg::CapacityDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ole_pkg::ole_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ole_pkg::ole_out_t  out_data_o
);
  import ole_pkg::*;

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_RD    = 10'b0000000010, // address presented, wait for data
    ST_DATA  = 10'b0000000100, // data available
    ST_EMIT  = 10'b0000001000, // dedupe: advance to next item
    ST_DRD   = 10'b0000010000, // dedupe: read item i
    ST_DHOLD = 10'b0000100000, // dedupe: capture item i
    ST_DJRD  = 10'b0001000000, // dedupe: read kept j
    ST_DJCMP = 10'b0010000000, // dedupe: compare
    ST_WAIT  = 10'b0100000000, // read out: wait for result taken
    ST_FIN   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0]          act_q, act_d;
  logic [ValWidth-1:0] val_q, val_d, cur_q, cur_d;
  logic [CW-1:0]       len_q, len_d, i_q, i_d, j_q, j_d, kept_q, kept_d;
  logic                hit_q, hit_d;
  logic                ov_q, ov_d;
  ole_out_t            od_q, od_d;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [ValWidth-1:0] wdata, rdata;

  ole_ram #(.Width(ValWidth), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  function automatic ole_out_t mk(logic f, logic r, logic h, logic [ValWidth-1:0] v,
                                  logic [CW-1:0] l, logic la);
    ole_out_t o;
    o.found = f; o.rejected = r; o.has_entry = h; o.entry_value = v;
    o.length = LenWidth'(l); o.last = la;
    return o;
  endfunction

  always_comb begin
    state_d = state_q; act_d = act_q; val_d = val_q; cur_d = cur_q;
    len_d = len_q; i_d = i_q; j_d = j_q; kept_d = kept_q; hit_d = hit_q;
    ov_d = ov_q; od_d = od_q;
    we = 1'b0; waddr = AW'(i_q); wdata = cur_q; raddr = AW'(i_q);
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d = in_data_i.action; val_d = in_data_i.operand_value;
          hit_d = 1'b0; kept_d = '0; j_d = '0;
          state_d = ST_FIN;
          case (in_data_i.action)
            ACT_INS_FRONT, ACT_INS_BACK: begin
              if (len_q >= CW'(Capacity)) hit_d = 1'b1; // reject
              else if (in_data_i.action == ACT_INS_BACK) begin
                we = 1'b1; waddr = AW'(len_q); wdata = in_data_i.operand_value;
                len_d = len_q + 1'b1;
              end else begin
                // shift from the front: i counts up, cur carries the value to write at i
                cur_d = in_data_i.operand_value; i_d = '0;
                state_d = (len_q == '0) ? ST_DATA : ST_RD;
              end
            end
            ACT_DELETE, ACT_SEARCH, ACT_READ_OUT: begin
              i_d = '0;
              if (len_q != '0) state_d = ST_RD;
            end
            ACT_DEDUPE: begin
              i_d = '0;
              if (len_q != '0) state_d = ST_DRD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: state_d = ST_DATA; // raddr = i
      ST_DATA: begin
        case (act_q)
          ACT_INS_FRONT: begin
            // rdata = old[i]; write carried value at i, carry old
            we = 1'b1; wdata = cur_q; cur_d = rdata;
            if (i_q == len_q) begin
              len_d = len_q + 1'b1; state_d = ST_FIN;
            end else begin
              i_d = i_q + 1'b1;
              state_d = (i_q + 1'b1 == len_q) ? ST_DATA : ST_RD;
            end
          end
          ACT_SEARCH: begin
            if (rdata == val_q) begin
              hit_d = 1'b1; state_d = ST_FIN;
            end else if (i_q + 1'b1 >= len_q) state_d = ST_FIN;
            else begin i_d = i_q + 1'b1; state_d = ST_RD; end
          end
          ACT_DELETE: begin
            // before hit: search; after hit: write entry i into slot i-1
            if (hit_q) begin
              we = 1'b1; waddr = AW'(i_q - 1'b1); wdata = rdata;
            end
            if (!hit_q && rdata == val_q) hit_d = 1'b1;
            if (i_q + 1'b1 >= len_q) begin
              if (hit_q || rdata == val_q) len_d = len_q - 1'b1;
              state_d = ST_FIN;
            end else begin i_d = i_q + 1'b1; state_d = ST_RD; end
          end
          default: begin // read out; hold while the previous result is unread
            if (!ov_d) begin
              ov_d = 1'b1;
              od_d = mk(1'b0, 1'b0, 1'b1, rdata, len_q, i_q + 1'b1 == len_q);
              state_d = (i_q + 1'b1 == len_q) ? ST_IDLE : ST_WAIT;
              i_d = i_q + 1'b1;
            end
          end
        endcase
      end
      ST_WAIT: if (!ov_d) state_d = ST_RD;
      ST_DRD: state_d = ST_DHOLD;
      ST_DHOLD: begin
        cur_d = rdata; j_d = '0;
        if (kept_q == '0) begin
          we = 1'b1; waddr = AW'(kept_q); wdata = rdata; kept_d = kept_q + 1'b1;
          state_d = ST_EMIT;
        end else begin raddr = '0; state_d = ST_DJCMP; end
      end
      ST_DJRD: begin raddr = AW'(j_q); state_d = ST_DJCMP; end
      ST_DJCMP: begin
        if (rdata == cur_q) state_d = ST_EMIT; // duplicate, drop
        else if (j_q + 1'b1 >= kept_q) begin
          we = 1'b1; waddr = AW'(kept_q); wdata = cur_q; kept_d = kept_q + 1'b1;
          state_d = ST_EMIT;
        end else begin j_d = j_q + 1'b1; raddr = AW'(j_q + 1'b1); state_d = ST_DJCMP;
        end
      end
      ST_EMIT: begin // dedupe: advance to next item
        if (i_q + 1'b1 >= len_q) begin len_d = kept_q; state_d = ST_FIN; end
        else begin i_d = i_q + 1'b1; raddr = AW'(i_q + 1'b1); state_d = ST_DHOLD; end
      end
      ST_FIN: begin
        if (!ov_d) begin
          ov_d = 1'b1;
          od_d = mk((act_q == ACT_SEARCH || act_q == ACT_DELETE) && hit_q,
                    (act_q == ACT_INS_FRONT || act_q == ACT_INS_BACK) && hit_q,
                    1'b0, '0, len_q, 1'b1);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_DRD) raddr = AW'(i_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; len_q <= '0; ov_q <= 1'b0;
      i_q <= '0; j_q <= '0; kept_q <= '0; hit_q <= 1'b0; act_q <= '0;
    end else begin
      state_q <= state_d; len_q <= len_d; ov_q <= ov_d;
      i_q <= i_d; j_q <= j_d; kept_q <= kept_d; hit_q <= hit_d; act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; cur_q <= cur_d; od_q <= od_d;
  end

`ifndef NO_ASSERTIONS
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= CW'(Capacity))
    else $error("length above capacity");
  a_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("accepted twice");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
`endif
endmodule

// ===== src/ole_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module ole_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
